[rtl/tdpt_pkg.sv]
// Shared constants for the trial-division prime test.
// No dependencies; imported by trial_division_prime_test and the testbench.
`timescale 1ns / 1ps

package tdpt_pkg;

  // 6k +/- 1 wheel
  localparam int unsigned FIRST_DIVISOR = 5;
  localparam int unsigned WHEEL_STEP    = 6;
  localparam int unsigned PAIR_GAP      = 2;
  localparam int unsigned SMALL_PRIME   = 3;

  // sequencer state codes
  localparam int unsigned STATE_BITS = 3;
  localparam logic [STATE_BITS-1:0] ST_IDLE = 3'd0;
  localparam logic [STATE_BITS-1:0] ST_CHK  = 3'd1;
  localparam logic [STATE_BITS-1:0] ST_DIV3 = 3'd2;
  localparam logic [STATE_BITS-1:0] ST_DIVA = 3'd3;
  localparam logic [STATE_BITS-1:0] ST_DIVB = 3'd4;
  localparam logic [STATE_BITS-1:0] ST_FIN  = 3'd5;

endpackage

[rtl/tdpt_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle; done_o flags completion of the divide.
// No dependencies.
`timescale 1ns / 1ps

module tdpt_div #(
  parameter int unsigned W = 31
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CW = $clog2(W);
  localparam logic [CW-1:0] LastCnt = CW'(W - 1);

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  shf_q, shf_d;   // dividend bits out at the top, quotient bits in at the bottom
  logic [W-1:0]  dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;

  logic [W:0]    rem_sh;
  logic [W:0]    diff;

  assign rem_sh = {rem_q, shf_q[W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    shf_d  = shf_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      shf_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        shf_d = {shf_q[W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[W-1:0];
        shf_d = {shf_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    shf_q <= shf_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = shf_q;
  assign rem_o  = rem_q;

endmodule

[rtl/trial_division_prime_test.sv]
// Trial-division primality test on the 6k +/- 1 wheel.
// Depends on tdpt_pkg and tdpt_div.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / candidate_i) takes one
//   unsigned VALUE_BITS-wide request at a time. Output channel
//   (out_valid_o / out_ready_i / is_prime_o) returns one bit per request,
//   in order.
//   Values 0..3 and even values are settled without a divide; others
//   take one divide by 3 plus two divides per tried divisor pair in the
//   serial divider, and the number of pairs grows with sqrt(candidate),
//   so the divider sets the pace.
//   One request is in work at a time; in_ready_o rises again as soon as
//   the result moves into the output register, so the next request can
//   start while that result waits.
//   Reset clears the sequencer and the output valid flag; no result is
//   pending afterwards.
//   If the receiver stalls, the result holds in the output register and
//   a following result waits in the sequencer until the register frees.
`timescale 1ns / 1ps

module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] candidate_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  is_prime_o
);

  localparam int unsigned VB = VALUE_BITS;
  localparam logic [VB-1:0] ValOne    = VB'(1);
  localparam logic [VB-1:0] DivThree  = VB'(SMALL_PRIME);
  localparam logic [VB-1:0] DivFirst  = VB'(FIRST_DIVISOR);
  localparam logic [VB-1:0] DivStep   = VB'(WHEEL_STEP);
  localparam logic [VB-1:0] DivGap    = VB'(PAIR_GAP);

  logic [STATE_BITS-1:0] state_q, state_d;
  logic [VB-1:0]         v_q, v_d;
  logic [VB-1:0]         d_q, d_d;
  logic                  res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_prime_q, out_prime_d;

  logic                  div_start;
  logic [VB-1:0]         div_divisor;
  logic                  div_done;
  logic [VB-1:0]         div_quot;
  logic [VB-1:0]         div_rem;

  tdpt_div #(
    .W (VB)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (v_q),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    d_d         = d_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_prime_d = out_prime_q;
    div_start   = 1'b0;
    div_divisor = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          v_d     = candidate_i;
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        priority if (v_q <= ValOne) begin
          res_d   = 1'b0;
          state_d = ST_FIN;
        end else if (v_q <= DivThree) begin
          res_d   = 1'b1;
          state_d = ST_FIN;
        end else if (!v_q[0]) begin
          res_d   = 1'b0;
          state_d = ST_FIN;
        end else begin
          div_start   = 1'b1;
          div_divisor = DivThree;
          state_d     = ST_DIV3;
        end
      end
      ST_DIV3: begin
        if (div_done) begin
          if (div_rem == '0) begin
            res_d   = 1'b0;
            state_d = ST_FIN;
          end else begin
            d_d         = DivFirst;
            div_start   = 1'b1;
            div_divisor = DivFirst;
            state_d     = ST_DIVA;
          end
        end
      end
      ST_DIVA: begin
        // quotient gives the d*d <= v test without a square
        if (div_done) begin
          priority if (d_q > div_quot) begin
            res_d   = 1'b1;
            state_d = ST_FIN;
          end else if (div_rem == '0) begin
            res_d   = 1'b0;
            state_d = ST_FIN;
          end else begin
            div_start   = 1'b1;
            div_divisor = d_q + DivGap;
            state_d     = ST_DIVB;
          end
        end
      end
      ST_DIVB: begin
        if (div_done) begin
          if (div_rem == '0) begin
            res_d   = 1'b0;
            state_d = ST_FIN;
          end else begin
            d_d         = d_q + DivStep;
            div_start   = 1'b1;
            div_divisor = d_d;
            state_d     = ST_DIVA;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_prime_d = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q         <= v_d;
    d_q         <= d_d;
    res_q       <= res_d;
    out_prime_q <= out_prime_d;
  end

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = out_prime_q;

endmodule

[rtl/tdpt_check.sv]
// Port-level checks for trial_division_prime_test, bound to the top level.
// Depends on trial_division_prime_test's port list.
`timescale 1ns / 1ps

module tdpt_check #(
  parameter int unsigned VALUE_BITS = 31
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic [VALUE_BITS-1:0] candidate_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  is_prime_o
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(is_prime_o))
    else $error("result changed or dropped while stalled");

  // one request in work at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while one is in work");

  // a result never appears the cycle right after a request is taken
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind trial_division_prime_test tdpt_check #(.VALUE_BITS(VALUE_BITS)) u_tdpt_check (.*);

[verif/testbench.sv]
// Self-checking bench for trial_division_prime_test: randomized valid/ready traffic on both sides.
// Depends on tdpt_pkg and the RTL of trial_division_prime_test; primality is recomputed here.
`timescale 1ns / 1ps

module testbench;
  import tdpt_pkg::*;

  localparam int unsigned VALUE_BITS       = 31;
  localparam longint unsigned VALUE_MAX    = (64'd1 << VALUE_BITS) - 1;
  localparam int unsigned RANDOM_REQS      = 76;
  localparam int unsigned LONG_HOLD_AT     = 30;
  localparam int unsigned LONG_HOLD_CYCLES = 30000;
  localparam int unsigned DRAIN_CYCLES     = 100;
  // run cut-off; full-width primes are the slowest requests
  localparam int unsigned CYCLE_LIMIT      = 3_000_000;

  typedef struct {
    logic [VALUE_BITS-1:0] candidate;
    bit                    is_prime;
  } verdict_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [VALUE_BITS-1:0] candidate_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  is_prime_o;

  logic [VALUE_BITS-1:0] candidates_to_send[$];
  verdict_t              verdicts_due[$];
  int unsigned           reqs_offered;
  int unsigned           reqs_accepted;
  int unsigned           results_seen;
  int unsigned           results_noted;
  int unsigned           send_gap;
  int unsigned           recv_stall;
  bit                    send_burst;
  bit                    recv_burst;
  bit                    long_hold_done;
  int unsigned           long_hold_left;
  logic                  long_hold;
  bit                    mismatch_seen;
  int unsigned           cycle_count;

  trial_division_prime_test #(
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .candidate_i(candidate_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .is_prime_o (is_prime_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // 6k +/- 1 trial division, square bound as d <= v / d
  function automatic bit primality_of(input logic [VALUE_BITS-1:0] value);
    longint unsigned v;
    longint unsigned d;
    v = value;
    if (v <= 1) return 1'b0;
    if (v <= SMALL_PRIME) return 1'b1;
    if (v % PAIR_GAP == 0 || v % SMALL_PRIME == 0) return 1'b0;
    d = FIRST_DIVISOR;
    while (d <= v / d) begin
      if (v % d == 0 || v % (d + PAIR_GAP) == 0) return 1'b0;
      d += WHEEL_STEP;
    end
    return 1'b1;
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && reqs_accepted != reqs_offered) begin
        // still waiting for the request to be taken
      end else if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (candidates_to_send.size() > 0) begin
        candidate_i <= candidates_to_send.pop_front();
        in_valid_i <= 1'b1;
        reqs_offered = reqs_offered + 1;
        if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 8);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // one long receiver hold so the block backs up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        long_hold_left = LONG_HOLD_CYCLES;
      end
      if (long_hold_left > 0) begin
        long_hold_left = long_hold_left - 1;
        long_hold <= 1'b1;
      end else begin
        long_hold <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (results_seen != results_noted) begin
        results_noted = results_seen;
        if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 8);
      end
      if (recv_stall > 0) begin
        recv_stall = recv_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !long_hold;
      end
    end
  end

  // monitor: predict on request, compare on result
  always @(posedge clk_i) begin
    verdict_t due;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        due.candidate = candidate_i;
        due.is_prime  = primality_of(candidate_i);
        verdicts_due.push_back(due);
        reqs_accepted <= reqs_accepted + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (verdicts_due.size() == 0) begin
          $error("is_prime: result %0b with no request outstanding", is_prime_o);
          mismatch_seen = 1'b1;
        end else begin
          due = verdicts_due.pop_front();
          if (is_prime_o !== due.is_prime) begin
            $error("is_prime: expected %0b, actual %0b (candidate %0d)",
                   due.is_prime, is_prime_o, due.candidate);
            mismatch_seen = 1'b1;
          end
        end
        results_seen <= results_seen + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("trial_division_prime_test: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned     pick;
    longint unsigned factor;
    longint unsigned value;
    int unsigned     small_factors[6];
    int unsigned     total_reqs;

    small_factors = '{2, 3, 5, 7, 11, 13};
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    candidate_i    = '0;
    out_ready_i    = 1'b0;
    reqs_offered   = 0;
    reqs_accepted  = 0;
    results_seen   = 0;
    results_noted  = 0;
    send_gap       = 0;
    recv_stall     = 0;
    send_burst     = 1'b0;
    recv_burst     = 1'b0;
    long_hold_done = 1'b0;
    long_hold_left = 0;
    long_hold      = 1'b0;
    mismatch_seen  = 1'b0;
    cycle_count    = 0;

    // zero, one, the small primes, prime squares at the bound, both wheel
    // offsets, all-ones and alternating patterns at full width
    candidates_to_send = '{0, 1, 2, 3, 4, 5, 6, 7, 9, 25, 35, 49, 121, 143, 169, 289,
                           65521, 65535, 1073741824, 1431655765, 715827882,
                           2147483646, 2147483645, 2147483647};

    for (int i = 0; i < RANDOM_REQS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        value = $urandom_range(0, 4095);
      end else if (pick < 9) begin
        // wide multiple of a small prime factor, so it resolves quickly
        factor = small_factors[$urandom_range(0, 5)];
        value  = factor * $urandom_range(1, VALUE_MAX / factor);
      end else begin
        value = $urandom_range(0, 1 << 20);
      end
      candidates_to_send.push_back(value[VALUE_BITS-1:0]);
    end
    total_reqs = candidates_to_send.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (results_seen < total_reqs)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (!mismatch_seen) begin
      $display("trial_division_prime_test: match");
    end else begin
      $display("trial_division_prime_test: mismatch");
    end
    $finish;
  end

endmodule
